// ===== rtl/range_flow_frame_decoder_top_macros.svh =====
// Assertion macros for the range and flow frame decoder.
// Taken in by the top level; needs nothing else.
`ifndef RANGE_FLOW_FRAME_DECODER_TOP_MACROS_SVH
`define RANGE_FLOW_FRAME_DECODER_TOP_MACROS_SVH

// a in a cycle implies b in the same cycle
`define RFFD_ASSERT_IMPLY(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// a in a cycle implies b in the next cycle
`define RFFD_ASSERT_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

// ===== rtl/rffd_pkg.sv =====
// Shared types, constants and helpers of the range and flow frame decoder.
// Used by the top level, rffd_front and rffd_back; depends on nothing.
package rffd_pkg;

  typedef logic [4:0] pos_t;
  typedef logic [7:0] byte_t;

  localparam byte_t HDR0 = 8'hEF;
  localparam byte_t HDR1 = 8'h0F;
  localparam byte_t HDR2 = 8'h00;
  localparam byte_t HDR3 = 8'h51;

  localparam int PAYLOAD_BYTES = 8'h14;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam pos_t POS_HUNT    = 5'd0;
  localparam pos_t POS_FIRST   = 5'd1;
  localparam pos_t POS_SEQ     = 5'd4;
  localparam pos_t POS_PAYLOAD = 5'd6;
  localparam pos_t POS_CHECK   = 5'd26;

  // frame fields as taken off the wire, before the velocity products
  typedef struct packed {
    logic               frame_ok;
    logic [7:0]         sequence_res;
    logic [31:0]        distance_mm;
    logic [7:0]         signal_strength;
    logic [7:0]         range_accuracy;
    logic               range_valid;
    logic signed [15:0] flow_x;
    logic signed [15:0] flow_y;
    logic [7:0]         flow_quality;
    logic               flow_valid;
  } frame_rec_t;

  typedef struct packed {
    frame_rec_t         rec;
    logic signed [47:0] speed_x;
    logic signed [47:0] speed_y;
  } out_word_t;

  function automatic byte_t hdr_byte(input logic [1:0] idx);
    byte_t b;
    case (idx)
      2'd0:    b = HDR0;
      2'd1:    b = HDR1;
      2'd2:    b = HDR2;
      default: b = HDR3;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/range_flow_frame_decoder_top.sv =====
// Top level of the range and flow sensor frame decoder.
// Depends on rffd_pkg, rffd_front, rffd_queue, rffd_back and the assertion macros.
//
// Usage:
//   Input channel: one serial byte per word on rx_byte, taken when push is
//   high and full is low. full rises only while the checksum byte is due
//   and the frame queue has no room, so bytes flow at one per cycle.
//   Result channel: one word per complete frame (header EF 0F 00 51,
//   sequence, length, 20 payload bytes, sum checksum). While empty is low
//   the oldest result sits on the result ports; pop takes it.
//   frame_ok low marks a checksum error, and every other field is zero.
//   Path: after its checksum byte is taken, a result passes through the frame
//   queue, the velocity multiplier register and the result queue.
//   Throughput: one byte per cycle while full is low; the position counter
//   and the running checksum update on every accepted byte.
//   Stall: when pop stays low the result queue fills, then the frame queue,
//   and only then does full hold back the next checksum byte.
//   Reset (rst, synchronous): back to header hunt, checksum cleared, both
//   queues emptied.
module range_flow_frame_decoder_top #(
  parameter int QUEUE_DEPTH = rffd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [7:0]         rx_byte,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output logic               frame_ok,
  output logic [7:0]         sequence_res,
  output logic [31:0]        distance_mm,
  output logic [7:0]         signal_strength,
  output logic [7:0]         range_accuracy,
  output logic               range_valid,
  output logic signed [15:0] flow_x,
  output logic signed [15:0] flow_y,
  output logic [7:0]         flow_quality,
  output logic               flow_valid,
  output logic signed [47:0] speed_x,
  output logic signed [47:0] speed_y
);

  import rffd_pkg::*;

  `include "range_flow_frame_decoder_top_macros.svh"

  localparam int FW = $bits(frame_rec_t);

  logic          mid_push;
  logic          mid_full;
  logic          mid_pop;
  logic          mid_empty;
  frame_rec_t    front_rec;
  logic [FW-1:0] mid_data;
  out_word_t     res;
  logic          bad_word;
  logic          bad_data_zero;

  rffd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .rx_byte (rx_byte),
    .full    (full),
    .rec_push(mid_push),
    .rec     (front_rec),
    .rec_full(mid_full)
  );

  rffd_queue #(
    .WIDTH(FW),
    .DEPTH(QUEUE_DEPTH)
  ) u_mid_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (mid_push),
    .push_data(FW'(front_rec)),
    .full     (mid_full),
    .pop      (mid_pop),
    .pop_data (mid_data),
    .empty    (mid_empty)
  );

  rffd_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .rec_empty(mid_empty),
    .rec      (frame_rec_t'(mid_data)),
    .rec_pop  (mid_pop),
    .res      (res),
    .empty    (empty),
    .pop      (pop)
  );

  assign frame_ok        = res.rec.frame_ok;
  assign sequence_res    = res.rec.sequence_res;
  assign distance_mm     = res.rec.distance_mm;
  assign signal_strength = res.rec.signal_strength;
  assign range_accuracy  = res.rec.range_accuracy;
  assign range_valid     = res.rec.range_valid;
  assign flow_x          = res.rec.flow_x;
  assign flow_y          = res.rec.flow_y;
  assign flow_quality    = res.rec.flow_quality;
  assign flow_valid      = res.rec.flow_valid;
  assign speed_x         = res.speed_x;
  assign speed_y         = res.speed_y;

  assign bad_word      = !empty && !frame_ok;
  assign bad_data_zero = (distance_mm == 32'd0) && (speed_x == 48'sd0) && (speed_y == 48'sd0);

  `RFFD_ASSERT_IMPLY(a_no_push_when_full, clk, rst, mid_push, !mid_full, "push into full queue")
  `RFFD_ASSERT_IMPLY(a_full_only_on_backlog, clk, rst, full, mid_full, "stall without backlog")
  `RFFD_ASSERT_IMPLY(a_bad_frame_zeroed, clk, rst, bad_word, bad_data_zero, "bad frame has data")

endmodule

// ===== rtl/rffd_queue.sv =====
// Small first-in first-out queue of packed words.
// Uses no package; sized by its parameters.
module rffd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/rffd_front.sv =====
// Front end: header hunt, frame position, running checksum and payload capture.
// Depends on rffd_pkg; hands one frame record per finished frame to the queue.
module rffd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [7:0]          rx_byte,
  output logic                full,
  output logic                rec_push,
  output rffd_pkg::frame_rec_t rec,
  input  logic                rec_full
);

  import rffd_pkg::*;

  pos_t  pos;
  pos_t  pos_next;
  byte_t sum;
  byte_t sum_next;
  byte_t sequence_hold;
  byte_t payload [PAYLOAD_BYTES];
  logic  accept;
  logic  ok;
  logic [4:0] pay_idx;

  // only the checksum byte needs room downstream
  assign full    = (pos == POS_CHECK) && rec_full;
  assign accept  = push && !full;
  assign ok      = (rx_byte == sum);
  assign pay_idx = 5'(pos - POS_PAYLOAD);

  always_comb begin
    pos_next = pos;
    sum_next = sum;
    rec_push = 1'b0;
    if (accept) begin
      if (pos < POS_SEQ) begin
        if (rx_byte == hdr_byte(pos[1:0])) begin
          sum_next = ((pos == POS_HUNT) ? 8'd0 : sum) + rx_byte;
          pos_next = pos + 5'd1;
        end else if (rx_byte == HDR0) begin
          // restart on a fresh first header byte
          sum_next = HDR0;
          pos_next = POS_FIRST;
        end else begin
          sum_next = 8'd0;
          pos_next = POS_HUNT;
        end
      end else if (pos < POS_CHECK) begin
        sum_next = sum + rx_byte;
        pos_next = pos + 5'd1;
      end else begin
        rec_push = 1'b1;
        sum_next = 8'd0;
        pos_next = POS_HUNT;
      end
    end
  end

  // zero every field of a frame whose checksum fails
  always_comb begin
    rec.frame_ok        = ok;
    rec.sequence_res    = ok ? sequence_hold : 8'd0;
    rec.distance_mm     = ok ? {payload[7], payload[6], payload[5], payload[4]} : 32'd0;
    rec.signal_strength = ok ? payload[8] : 8'd0;
    rec.range_accuracy  = ok ? payload[9] : 8'd0;
    rec.range_valid     = ok && (payload[10] == 8'd1);
    rec.flow_x          = ok ? $signed({payload[13], payload[12]}) : 16'sd0;
    rec.flow_y          = ok ? $signed({payload[15], payload[14]}) : 16'sd0;
    rec.flow_quality    = ok ? payload[16] : 8'd0;
    rec.flow_valid      = ok && (payload[17] == 8'd1);
  end

  always_ff @(posedge clk) begin
    if (accept && (pos >= POS_PAYLOAD) && (pos < POS_CHECK)) begin
      payload[pay_idx] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= POS_HUNT;
      sum           <= 8'd0;
      sequence_hold <= 8'd0;
    end else begin
      pos <= pos_next;
      sum <= sum_next;
      if (accept && (pos == POS_SEQ)) begin
        sequence_hold <= rx_byte;
      end
    end
  end

endmodule

// ===== rtl/rffd_back.sv =====
// Back end: velocity products and the result queue.
// Depends on rffd_pkg and rffd_queue; drains frame records from the middle queue.
module rffd_back #(
  parameter int QUEUE_DEPTH = rffd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rec_empty,
  input  rffd_pkg::frame_rec_t rec,
  output logic                 rec_pop,
  output rffd_pkg::out_word_t  res,
  output logic                 empty,
  input  logic                 pop
);

  import rffd_pkg::*;

  localparam int RW = $bits(out_word_t);

  logic               s1_valid;
  out_word_t          s1;
  logic               out_full;
  logic               s1_take;
  logic signed [48:0] prod_x;
  logic signed [48:0] prod_y;
  logic [RW-1:0]      out_data;

  // distance is unsigned, so widen it with a zero sign bit
  assign prod_x  = rec.flow_x * $signed({1'b0, rec.distance_mm});
  assign prod_y  = rec.flow_y * $signed({1'b0, rec.distance_mm});
  assign s1_take = !s1_valid || !out_full;
  assign rec_pop = !rec_empty && s1_take;

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      s1.rec     <= rec;
      s1.speed_x <= prod_x[47:0];
      s1.speed_y <= prod_y[47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_take) begin
      s1_valid <= !rec_empty;
    end
  end

  rffd_queue #(
    .WIDTH(RW),
    .DEPTH(QUEUE_DEPTH)
  ) u_out_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (s1_valid),
    .push_data(RW'(s1)),
    .full     (out_full),
    .pop      (pop),
    .pop_data (out_data),
    .empty    (empty)
  );

  assign res = out_word_t'(out_data);

endmodule
